@@ sv/mcws_pkg.sv @@
// shared types, constants and helpers for the mecanum command to wheel speed pipeline
package mcws_pkg;

  // datapath widths
  localparam int XY_W  = 34;   // cordic vector, q30 with headroom
  localparam int Z_W   = 26;   // cordic angle, 2^-16 degree
  localparam int ANG_W = 17;   // yaw after widening, 1/128 degree
  localparam int NUM_W = 36;   // signed wheel numerator
  localparam int MAG_W = 35;   // numerator magnitude and quotient
  localparam int REM_W = 16;   // divider remainder
  localparam int ADDR_W = 5;

  // motion modes (normal mode needs no special handling)
  localparam logic [1:0] MODE_STOP   = 2'd0;
  localparam logic [1:0] MODE_FOLLOW = 2'd2;
  localparam logic [1:0] MODE_SPIN   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MAX_LIN   = 3'd0;
  localparam logic [2:0] REG_MAX_ANG   = 3'd1;
  localparam logic [2:0] REG_MAX_WHEEL = 3'd2;
  localparam logic [2:0] REG_RADIUS    = 3'd3;
  localparam logic [2:0] REG_BASE      = 3'd4;
  localparam logic [2:0] REG_TRACK     = 3'd5;

  // register reset values
  localparam logic [14:0] RST_MAX_LIN   = 15'd3000;
  localparam logic [14:0] RST_MAX_ANG   = 15'd6000;
  localparam logic [18:0] RST_MAX_WHEEL = 19'd100000;
  localparam logic [15:0] RST_RADIUS    = 16'd7600;
  localparam logic [11:0] RST_BASE      = 12'd400;
  localparam logic [11:0] RST_TRACK     = 12'd400;

  // fixed point constants
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [22:0]             FOLLOW_GAIN     = 23'd6862914;
  localparam logic [14:0]             SPIN_RATE       = 15'd6000;
  localparam logic signed [ANG_W-1:0] HALF_TURN       = 17'sd23040;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN    = 17'sd11520;
  localparam logic signed [ANG_W-1:0] FULL_TURN       = 17'sd46080;
  localparam logic signed [17:0]      LIN_SCALE       = 18'sd100000;
  localparam logic [6:0]              ARM_SCALE       = 7'd50;
  localparam logic [15:0]             MIN_RADIUS      = 16'd100;

  typedef struct packed {
    logic              robot_enabled;
    logic              emergency_stop;
    logic              safe_mode;
    logic [1:0]        cmd_mode;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_wz;
    logic              field_relative;
    logic signed [15:0] chassis_yaw;
    logic              yaw_valid;
    logic              gimbal_online;
    logic signed [15:0] gimbal_yaw;
  } mcws_in_t;

  typedef struct packed {
    logic [1:0]         applied_mode;
    logic signed [15:0] applied_vx;
    logic signed [15:0] applied_vy;
    logic signed [15:0] applied_wz;
    logic signed [19:0] wheel_front_left;
    logic signed [19:0] wheel_front_right;
    logic signed [19:0] wheel_rear_left;
    logic signed [19:0] wheel_rear_right;
    logic               drive_enabled;
  } mcws_out_t;

  typedef struct packed {
    logic [14:0] max_linear_speed;
    logic [14:0] max_angular_speed;
    logic [18:0] max_wheel_speed;
    logic [15:0] tire_radius;
    logic [11:0] wheel_base;
    logic [11:0] track_width;
  } mcws_cfg_t;

  // command as it travels down the pipe
  typedef struct packed {
    logic               go;
    logic               rot;
    logic [1:0]         mode;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
  } mcws_cmd_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [22:0] atan_lookup(input int unsigned i);
    logic [22:0] a;
    begin
      case (i)
        0: a = 23'd2949120;
        1: a = 23'd1740967;
        2: a = 23'd919879;
        3: a = 23'd466945;
        4: a = 23'd234379;
        5: a = 23'd117304;
        6: a = 23'd58666;
        7: a = 23'd29335;
        8: a = 23'd14668;
        9: a = 23'd7334;
        10: a = 23'd3667;
        11: a = 23'd1833;
        12: a = 23'd917;
        13: a = 23'd458;
        14: a = 23'd229;
        15: a = 23'd115;
        16: a = 23'd57;
        17: a = 23'd29;
        18: a = 23'd14;
        19: a = 23'd7;
        20: a = 23'd4;
        21: a = 23'd2;
        22: a = 23'd1;
        default: a = 23'd0;
      endcase
      atan_lookup = a;
    end
  endfunction

  // clamp to +-lim
  function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                 input logic [14:0] lim);
    logic signed [16:0] l;
    logic signed [16:0] vv;
    begin
      l  = signed'({2'b00, lim});
      vv = 17'(v);
      if (vv > l) clamp16 = l[15:0];
      else if (vv < -l) clamp16 = 16'(-l);
      else clamp16 = v;
    end
  endfunction

  // saturate to the signed 16 bit range
  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    begin
      if (v > 21'sd32767) sat16 = 16'sh7fff;
      else if (v < -21'sd32768) sat16 = 16'sh8000;
      else sat16 = v[15:0];
    end
  endfunction

endpackage

@@ sv/mcws_prep.sv @@
// front stages: request register, limits, mode override and yaw folding
module mcws_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  mcws_pkg::mcws_in_t            in_data,
  input  mcws_pkg::mcws_cfg_t           cfg,
  output logic                          valid,
  output mcws_pkg::mcws_cmd_t           cmd,
  output logic signed [mcws_pkg::Z_W-1:0] z,
  output logic                          neg
);
  import mcws_pkg::*;

  logic        v1;
  mcws_in_t    d1;

  logic               v2;
  mcws_cmd_t          c2;
  logic               follow2;
  logic               spin2;
  logic               gpos2;
  logic [31:0]        gg2;
  logic signed [Z_W-1:0] z2;
  logic               neg2;

  // stage 2 logic
  logic               ready;
  logic               follow;
  logic               use_chassis;
  logic signed [15:0] yaw_sel;
  logic signed [ANG_W-1:0] a_wrap;
  logic signed [ANG_W-1:0] a_fold;
  logic               a_neg;
  logic [15:0]        g_abs;
  mcws_cmd_t          c2_next;

  // stage 3 logic
  logic [54:0]        prod;
  logic [54:0]        prod_rnd;
  logic [22:0]        p;
  logic signed [23:0] wz_f;
  logic signed [23:0] ang_l;
  logic signed [15:0] wz_follow;
  logic [14:0]        wz_spin;
  mcws_cmd_t          cmd_next;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= in_data;
    end
  end

  // readiness, clamps, angle selection and folding
  always_comb begin
    ready = d1.robot_enabled && !d1.emergency_stop && !d1.safe_mode;
    follow = (d1.cmd_mode == MODE_FOLLOW) && d1.gimbal_online;
    use_chassis = d1.field_relative && d1.yaw_valid;
    yaw_sel = use_chassis ? d1.chassis_yaw : d1.gimbal_yaw;
    a_wrap = ANG_W'(yaw_sel);
    if (a_wrap > HALF_TURN) a_wrap = a_wrap - FULL_TURN;
    else if (a_wrap < -HALF_TURN) a_wrap = a_wrap + FULL_TURN;
    a_neg = 1'b0;
    a_fold = a_wrap;
    if (a_wrap > QUARTER_TURN) begin
      a_fold = a_wrap - HALF_TURN;
      a_neg = 1'b1;
    end else if (a_wrap < -QUARTER_TURN) begin
      a_fold = a_wrap + HALF_TURN;
      a_neg = 1'b1;
    end
    g_abs = d1.gimbal_yaw[15] ? 16'(-d1.gimbal_yaw) : 16'(d1.gimbal_yaw);
    c2_next.go = ready && (d1.cmd_mode != MODE_STOP);
    c2_next.rot = use_chassis || follow;
    c2_next.mode = d1.cmd_mode;
    c2_next.vx = clamp16(d1.cmd_vx, cfg.max_linear_speed);
    c2_next.vy = clamp16(d1.cmd_vy, cfg.max_linear_speed);
    c2_next.wz = clamp16(d1.cmd_wz, cfg.max_angular_speed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c2_next;
      follow2 <= follow;
      spin2 <= (d1.cmd_mode == MODE_SPIN);
      gpos2 <= (d1.gimbal_yaw > 16'sd0);
      gg2 <= 32'(g_abs) * 32'(g_abs);
      z2 <= Z_W'(a_fold) <<< 9;
      neg2 <= a_neg;
    end
  end

  // follow rate and spin override
  always_comb begin
    prod = 55'(gg2) * 55'(FOLLOW_GAIN);
    prod_rnd = prod + 55'(33'h0_8000_0000);
    p = prod_rnd[54:32];
    wz_f = gpos2 ? -signed'({1'b0, p}) : signed'({1'b0, p});
    ang_l = signed'({9'b0, cfg.max_angular_speed});
    if (wz_f > ang_l) wz_follow = ang_l[15:0];
    else if (wz_f < -ang_l) wz_follow = 16'(-ang_l);
    else wz_follow = wz_f[15:0];
    wz_spin = (cfg.max_angular_speed < SPIN_RATE) ? cfg.max_angular_speed : SPIN_RATE;
    cmd_next = c2;
    if (follow2) cmd_next.wz = wz_follow;
    else if (spin2) cmd_next.wz = signed'({1'b0, wz_spin});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cmd <= cmd_next;
      z <= z2;
      neg <= neg2;
    end
  end

endmodule

@@ sv/mcws_cordic.sv @@
// pipelined rotation-mode cordic, one micro-rotation per stage
module mcws_cordic #(
  parameter int STEPS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  mcws_pkg::mcws_cmd_t              in_cmd,
  input  logic signed [mcws_pkg::Z_W-1:0]  in_z,
  input  logic                             in_neg,
  output logic                             valid,
  output mcws_pkg::mcws_cmd_t              cmd,
  output logic signed [mcws_pkg::XY_W-1:0] x,
  output logic signed [mcws_pkg::XY_W-1:0] y,
  output logic                             neg
);
  import mcws_pkg::*;

  logic                  vs [STEPS];
  mcws_cmd_t             cs [STEPS];
  logic signed [XY_W-1:0] xs [STEPS];
  logic signed [XY_W-1:0] ys [STEPS];
  logic signed [Z_W-1:0]  zs [STEPS];
  logic                  ns [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(atan_lookup(k));
    logic                   vi;
    mcws_cmd_t              ci;
    logic signed [XY_W-1:0] xi;
    logic signed [XY_W-1:0] yi;
    logic signed [Z_W-1:0]  zi;
    logic                   ni;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign ci = in_cmd;
      assign xi = CORDIC_GAIN_Q30;
      assign yi = '0;
      assign zi = in_z;
      assign ni = in_neg;
    end else begin : g_next
      assign vi = vs[k-1];
      assign ci = cs[k-1];
      assign xi = xs[k-1];
      assign yi = ys[k-1];
      assign zi = zs[k-1];
      assign ni = ns[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= vi;
      end
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        cs[k] <= ci;
        ns[k] <= ni;
        if (!zi[Z_W-1]) begin
          xs[k] <= xi - (yi >>> k);
          ys[k] <= yi + (xi >>> k);
          zs[k] <= zi - ATAN_K;
        end else begin
          xs[k] <= xi + (yi >>> k);
          ys[k] <= yi - (xi >>> k);
          zs[k] <= zi + ATAN_K;
        end
      end
    end
  end

  assign valid = vs[STEPS-1];
  assign cmd   = cs[STEPS-1];
  assign x     = xs[STEPS-1];
  assign y     = ys[STEPS-1];
  assign neg   = ns[STEPS-1];

endmodule

@@ sv/mcws_solve.sv @@
// frame rotation and mecanum wheel numerators
module mcws_solve (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  mcws_pkg::mcws_cmd_t              in_cmd,
  input  logic signed [mcws_pkg::XY_W-1:0] in_x,
  input  logic signed [mcws_pkg::XY_W-1:0] in_y,
  input  logic                             in_neg,
  input  mcws_pkg::mcws_cfg_t              cfg,
  output logic                             valid,
  output mcws_pkg::mcws_cmd_t              cmd,
  output logic [3:0][mcws_pkg::MAG_W-1:0]  mag,
  output logic [3:0]                       sgn
);
  import mcws_pkg::*;

  localparam logic signed [50:0] ROUND_Q30 = 51'sd536870912;

  // stage 1
  logic                   v1;
  mcws_cmd_t              c1;
  logic signed [49:0]     pxc, pys, pxs, pyc;
  logic signed [XY_W-1:0] cosv, sinv;

  // stage 2
  logic                   v2;
  mcws_cmd_t              c2;
  logic signed [50:0]     sx, sy;
  mcws_cmd_t              c2_next;

  // stage 3
  logic                   v3;
  mcws_cmd_t              c3;
  logic signed [NUM_W-1:0] vt, wt, arm;
  logic signed [16:0]     dv, sv;
  logic [12:0]            bt;
  logic [18:0]            karm;
  logic signed [19:0]     ks;

  // stage 4
  logic signed [NUM_W-1:0] n [4];
  logic [15:0]            radius;
  logic [MAG_W-1:0]       half_r;

  // sign correction and products
  always_comb begin
    cosv = in_neg ? -in_x : in_x;
    sinv = in_neg ? -in_y : in_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= in_cmd;
      pxc <= in_cmd.vx * cosv;
      pys <= in_cmd.vy * sinv;
      pxs <= in_cmd.vx * sinv;
      pyc <= in_cmd.vy * cosv;
    end
  end

  // round, shift and saturate the rotated speeds
  always_comb begin
    sx = 51'(pxc) + 51'(pys) + ROUND_Q30;
    sy = 51'(pyc) - 51'(pxs) + ROUND_Q30;
    c2_next = c1;
    if (c1.rot) begin
      c2_next.vx = sat16(sx[50:30]);
      c2_next.vy = sat16(sy[50:30]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c2_next;
    end
  end

  // linear and turning terms
  always_comb begin
    dv = 17'(c2.vx) - 17'(c2.vy);
    sv = 17'(c2.vx) + 17'(c2.vy);
    bt = 13'(cfg.wheel_base) + 13'(cfg.track_width);
    karm = 19'(bt) * 19'(ARM_SCALE);
    ks = signed'({1'b0, karm});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c2;
      vt <= dv * LIN_SCALE;
      wt <= sv * LIN_SCALE;
      arm <= c2.wz * ks;
    end
  end

  // wheel numerators, magnitude plus half radius for rounding
  always_comb begin
    n[0] = vt - arm;
    n[1] = wt + arm;
    n[2] = wt - arm;
    n[3] = vt + arm;
    radius = (cfg.tire_radius < MIN_RADIUS) ? MIN_RADIUS : cfg.tire_radius;
    half_r = MAG_W'(radius >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd <= c3;
      for (int i = 0; i < 4; i++) begin
        sgn[i] <= n[i][NUM_W-1];
        mag[i] <= (n[i][NUM_W-1] ? MAG_W'(-n[i]) : MAG_W'(n[i])) + half_r;
      end
    end
  end

endmodule

@@ sv/mcws_div.sv @@
// pipelined restoring divider for four wheels, one quotient bit per stage, and output register
module mcws_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  mcws_pkg::mcws_cmd_t             in_cmd,
  input  logic [3:0][mcws_pkg::MAG_W-1:0] in_mag,
  input  logic [3:0]                      in_sgn,
  input  mcws_pkg::mcws_cfg_t             cfg,
  output logic                            valid,
  output mcws_pkg::mcws_out_t             data
);
  import mcws_pkg::*;

  logic [15:0] radius;

  logic                          vs  [MAG_W];
  mcws_cmd_t                     cs  [MAG_W];
  logic [3:0]                    ss  [MAG_W];
  logic [3:0][REM_W-1:0]         rs  [MAG_W];
  logic [3:0][MAG_W-1:0]         nqs [MAG_W];

  logic [3:0][18:0]              qc;
  logic signed [19:0]            w [4];
  mcws_out_t                     data_next;

  assign radius = (cfg.tire_radius < MIN_RADIUS) ? MIN_RADIUS : cfg.tire_radius;

  for (genvar k = 0; k < MAG_W; k++) begin : g_stage
    logic                  vi;
    mcws_cmd_t             ci;
    logic [3:0]            si;
    logic [3:0][REM_W-1:0] ri;
    logic [3:0][MAG_W-1:0] nqi;
    logic [3:0][REM_W:0]   r2;
    logic [3:0]            ge;

    if (k == 0) begin : g_first
      assign vi  = in_valid;
      assign ci  = in_cmd;
      assign si  = in_sgn;
      assign ri  = '0;
      assign nqi = in_mag;
    end else begin : g_next
      assign vi  = vs[k-1];
      assign ci  = cs[k-1];
      assign si  = ss[k-1];
      assign ri  = rs[k-1];
      assign nqi = nqs[k-1];
    end

    // trial subtract on the remainder with the next dividend bit shifted in
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        r2[l] = {ri[l], nqi[l][MAG_W-1]};
        ge[l] = (r2[l] >= {1'b0, radius});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[k] <= ci;
        ss[k] <= si;
        for (int l = 0; l < 4; l++) begin
          rs[k][l] <= ge[l] ? REM_W'(r2[l] - {1'b0, radius}) : r2[l][REM_W-1:0];
          nqs[k][l] <= {nqi[l][MAG_W-2:0], ge[l]};
        end
      end
    end
  end

  // wheel clamp, sign and stop masking
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (nqs[MAG_W-1][l] > MAG_W'(cfg.max_wheel_speed)) qc[l] = cfg.max_wheel_speed;
      else qc[l] = nqs[MAG_W-1][l][18:0];
      w[l] = ss[MAG_W-1][l] ? -signed'({1'b0, qc[l]}) : signed'({1'b0, qc[l]});
    end
    data_next = '0;
    if (cs[MAG_W-1].go) begin
      data_next.applied_mode = cs[MAG_W-1].mode;
      data_next.applied_vx = cs[MAG_W-1].vx;
      data_next.applied_vy = cs[MAG_W-1].vy;
      data_next.applied_wz = cs[MAG_W-1].wz;
      data_next.wheel_front_left = w[0];
      data_next.wheel_front_right = w[1];
      data_next.wheel_rear_left = w[2];
      data_next.wheel_rear_right = w[3];
      data_next.drive_enabled = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= vs[MAG_W-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

@@ sv/mecanum_command_to_wheel_speeds_top.sv @@
// top level: register file, pipeline stall control and stage chain
//
// Mecanum command to wheel speeds. One request on the input channel carries a
// motion command with readiness flags and yaw feedback; one result comes out
// with the applied mode, body speeds and four clamped wheel speeds.
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data; a
// request moves at a clock edge with valid high and stall low.
// Pipeline: three front stages, one cordic stage per step, four rotation and
// solve stages, one divider stage per quotient bit (35), and the output
// register. Throughput: one request per cycle while no result is held by
// out_stall; every stage is pipelined, including the per-bit divider.
// Stall: when a result is held by out_stall the whole pipeline freezes and
// in_stall is raised; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and loads the register
// defaults. Registers sit on an APB port at byte address 4*index and should
// be written only while the pipeline is empty.
module mecanum_command_to_wheel_speeds_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mcws_pkg::mcws_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mcws_pkg::mcws_out_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcws_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mcws_pkg::*;

  mcws_cfg_t cfg;
  logic      en;
  logic [2:0] reg_idx;

  logic                   p_valid;
  mcws_cmd_t              p_cmd;
  logic signed [Z_W-1:0]  p_z;
  logic                   p_neg;

  logic                   c_valid;
  mcws_cmd_t              c_cmd;
  logic signed [XY_W-1:0] c_x, c_y;
  logic                   c_neg;

  logic                   s_valid;
  mcws_cmd_t              s_cmd;
  logic [3:0][MAG_W-1:0]  s_mag;
  logic [3:0]             s_sgn;

  // whole pipe advances unless a held result is waiting
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // register file
  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_linear_speed <= RST_MAX_LIN;
      cfg.max_angular_speed <= RST_MAX_ANG;
      cfg.max_wheel_speed <= RST_MAX_WHEEL;
      cfg.tire_radius <= RST_RADIUS;
      cfg.wheel_base <= RST_BASE;
      cfg.track_width <= RST_TRACK;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MAX_LIN: cfg.max_linear_speed <= pwdata[14:0];
        REG_MAX_ANG: cfg.max_angular_speed <= pwdata[14:0];
        REG_MAX_WHEEL: cfg.max_wheel_speed <= pwdata[18:0];
        REG_RADIUS: cfg.tire_radius <= pwdata[15:0];
        REG_BASE: cfg.wheel_base <= pwdata[11:0];
        REG_TRACK: cfg.track_width <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_MAX_LIN: prdata = 32'(cfg.max_linear_speed);
      REG_MAX_ANG: prdata = 32'(cfg.max_angular_speed);
      REG_MAX_WHEEL: prdata = 32'(cfg.max_wheel_speed);
      REG_RADIUS: prdata = 32'(cfg.tire_radius);
      REG_BASE: prdata = 32'(cfg.wheel_base);
      REG_TRACK: prdata = 32'(cfg.track_width);
      default: prdata = '0;
    endcase
  end

  mcws_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .valid    (p_valid),
    .cmd      (p_cmd),
    .z        (p_z),
    .neg      (p_neg)
  );

  mcws_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p_valid),
    .in_cmd   (p_cmd),
    .in_z     (p_z),
    .in_neg   (p_neg),
    .valid    (c_valid),
    .cmd      (c_cmd),
    .x        (c_x),
    .y        (c_y),
    .neg      (c_neg)
  );

  mcws_solve u_solve (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid),
    .in_cmd   (c_cmd),
    .in_x     (c_x),
    .in_y     (c_y),
    .in_neg   (c_neg),
    .cfg      (cfg),
    .valid    (s_valid),
    .cmd      (s_cmd),
    .mag      (s_mag),
    .sgn      (s_sgn)
  );

  mcws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_valid),
    .in_cmd   (s_cmd),
    .in_mag   (s_mag),
    .in_sgn   (s_sgn),
    .cfg      (cfg),
    .valid    (out_valid),
    .data     (out_data)
  );

  // input is held back only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // a stopped result carries no speeds
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.drive_enabled |->
      out_data.applied_mode == MODE_STOP && out_data.applied_vx == 16'sd0 &&
      out_data.applied_wz == 16'sd0 && out_data.wheel_front_left == 20'sd0 &&
      out_data.wheel_rear_right == 20'sd0)
    else $error("stopped result with nonzero fields");

  // driving implies a moving mode
  a_drive_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_enabled |-> out_data.applied_mode != MODE_STOP)
    else $error("drive enabled in stop mode");

endmodule
